// File: src/bpru_pkg.sv
// shared types and constants of the pixel replicating upscaler
`default_nettype none

package bpru_pkg;

  localparam int unsigned PixelWidth    = 24;
  localparam int unsigned PadWidth      = 2;
  localparam int unsigned ScaleWidth    = 5;
  localparam int unsigned RowPixWidth   = 11;
  localparam int unsigned CfgDataWidth  = 11;
  localparam int unsigned CfgIdxWidth   = 1;

  localparam int unsigned MaxRowPixels  = 1024;
  localparam int unsigned MaxScale      = 16;

  localparam logic [ScaleWidth-1:0]  ScaleReset  = ScaleWidth'(1);
  localparam logic [RowPixWidth-1:0] RowPixReset = RowPixWidth'(1);

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgScale     = 1'b0,
    CfgRowPixels = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    ActPixel   = 1'b0,
    ActAdvance = 1'b1
  } action_e;

endpackage

`default_nettype wire

// File: src/bmp_pixel_replicating_upscaler.sv
// Nearest-neighbour integer upscaler for rows of 24-bit pixels. A pixel
// transaction stores its pixel in the line store and produces it scale times;
// once a full row is in, advance transactions replay the stored line scale-1
// more times, one stored pixel per transaction. An item yields scale results
// (scale clamped to 1..MAX_SCALE), one per cycle from a single result register
// unless the output stalls; an item of the wrong kind yields one error result.
// The next item is taken in the cycle its predecessor's last result leaves, so
// the block takes no new item while results of the current one remain.
// Replayed pixels come from the line store's registered read port, issued as
// the advance transaction is taken. The line store needs no clearing after reset.
`default_nettype none

module bmp_pixel_replicating_upscaler #(
  parameter int unsigned MAX_ROW_PIXELS = bpru_pkg::MaxRowPixels,
  parameter int unsigned MAX_SCALE      = bpru_pkg::MaxScale
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // configuration
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [bpru_pkg::CfgIdxWidth-1:0]   cfg_index_i,
  input  wire logic [bpru_pkg::CfgDataWidth-1:0]  cfg_data_i,
  // input items
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               action_i,
  input  wire logic [bpru_pkg::PixelWidth-1:0]    pixel_i,
  // results
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic      [bpru_pkg::PixelWidth-1:0]    out_pixel_o,
  output logic      [bpru_pkg::PadWidth-1:0]      pad_bytes_o,
  output logic                                    row_end_o,
  output logic                                    run_last_o,
  output logic                                    replay_pending_o,
  output logic                                    error_o
);

  import bpru_pkg::*;

  localparam int unsigned ColWidth = (MAX_ROW_PIXELS > 1) ? $clog2(MAX_ROW_PIXELS) : 1;
  localparam int unsigned WidWidth = $clog2(MAX_ROW_PIXELS + 1);
  localparam int unsigned RepWidth = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

  // configuration registers
  logic [ScaleWidth-1:0]  scale_q;
  logic [RowPixWidth-1:0] row_pixels_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q      <= ScaleReset;
      row_pixels_q <= RowPixReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgScale:     scale_q      <= cfg_data_i[ScaleWidth-1:0];
        CfgRowPixels: row_pixels_q <= cfg_data_i[RowPixWidth-1:0];
        default:      ;
      endcase
    end
  end

  // clamped scale (minus one) and width
  logic [RepWidth-1:0] scale_m1;
  logic [WidWidth-1:0] eff_w;
  logic [1:0]          w_lo, n_lo;
  logic [3:0]          pad_prod;
  logic [PadWidth-1:0] pad;

  always_comb begin
    if (scale_q == '0) begin
      scale_m1 = '0;
    end else if (32'(scale_q) > MAX_SCALE) begin
      scale_m1 = RepWidth'(MAX_SCALE - 1);
    end else begin
      scale_m1 = RepWidth'(32'(scale_q) - 32'd1);
    end
    if (row_pixels_q == '0) begin
      eff_w = WidWidth'(1);
    end else if (32'(row_pixels_q) > MAX_ROW_PIXELS) begin
      eff_w = WidWidth'(MAX_ROW_PIXELS);
    end else begin
      eff_w = WidWidth'(row_pixels_q);
    end
    // only the low two bits of width and scale matter for the pad count
    w_lo     = 2'(eff_w);
    n_lo     = 2'(32'(scale_m1) + 32'd1);
    pad_prod = 4'(w_lo) * 4'(n_lo);
    pad      = pad_prod[PadWidth-1:0];
  end

  // row state
  logic [ColWidth-1:0] fill_q, fill_d;
  logic [ColWidth-1:0] replay_col_q, replay_col_d;
  logic [RepWidth-1:0] replays_q, replays_d;

  // result run register
  logic                  run_valid_q, run_valid_d;
  logic [RepWidth-1:0]   cnt_q, cnt_d;
  logic [PixelWidth-1:0] pix_q, pix_d;
  logic                  from_ram_q, from_ram_d;
  logic                  end_q, end_d;
  logic [PadWidth-1:0]   pad_q, pad_d;
  logic                  pend_q, pend_d;
  logic                  err_q, err_d;

  logic                  in_acc, out_acc, run_done, wrong_kind, row_done;
  logic                  ram_we, ram_re;
  logic [PixelWidth-1:0] ram_rdata;

  assign out_acc    = out_valid_o && !out_stall_i;
  assign run_done   = out_acc && (cnt_q == '0);
  assign in_stall_o = run_valid_q && !run_done;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign wrong_kind = (action_i == ActPixel) != (replays_q == '0);

  always_comb begin
    fill_d       = fill_q;
    replay_col_d = replay_col_q;
    replays_d    = replays_q;
    run_valid_d  = run_valid_q;
    cnt_d        = cnt_q;
    pix_d        = pix_q;
    from_ram_d   = from_ram_q;
    end_d        = end_q;
    pad_d        = pad_q;
    pend_d       = pend_q;
    err_d        = err_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    row_done     = 1'b0;

    if (run_done) begin
      run_valid_d = 1'b0;
    end else if (out_acc) begin
      cnt_d = cnt_q - RepWidth'(1);
    end

    if (in_acc) begin
      run_valid_d = 1'b1;
      if (wrong_kind) begin
        cnt_d      = '0;
        pix_d      = '0;
        from_ram_d = 1'b0;
        end_d      = 1'b0;
        pad_d      = '0;
        pend_d     = (replays_q != '0);
        err_d      = 1'b1;
      end else begin
        if (action_i == ActPixel) begin
          ram_we   = 1'b1;
          row_done = (32'(fill_q) + 32'd1) >= 32'(eff_w);
          if (row_done) begin
            fill_d       = '0;
            replays_d    = scale_m1;
            replay_col_d = '0;
          end else begin
            fill_d = fill_q + ColWidth'(1);
          end
          pix_d      = pixel_i;
          from_ram_d = 1'b0;
        end else begin
          ram_re   = 1'b1;
          row_done = (32'(replay_col_q) + 32'd1) >= 32'(eff_w);
          if (row_done) begin
            replay_col_d = '0;
            replays_d    = replays_q - RepWidth'(1);
          end else begin
            replay_col_d = replay_col_q + ColWidth'(1);
          end
          from_ram_d = 1'b1;
        end
        cnt_d  = scale_m1;
        end_d  = row_done;
        pad_d  = pad;
        pend_d = (replays_d != '0);
        err_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q       <= '0;
      replay_col_q <= '0;
      replays_q    <= '0;
      run_valid_q  <= 1'b0;
      cnt_q        <= '0;
    end else begin
      fill_q       <= fill_d;
      replay_col_q <= replay_col_d;
      replays_q    <= replays_d;
      run_valid_q  <= run_valid_d;
      cnt_q        <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q      <= pix_d;
    from_ram_q <= from_ram_d;
    end_q      <= end_d;
    pad_q      <= pad_d;
    pend_q     <= pend_d;
    err_q      <= err_d;
  end

  // read data holds until the next advance transaction, which only comes
  // once the current run has gone
  bpru_ram #(
    .Width (PixelWidth),
    .Depth (MAX_ROW_PIXELS)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_q),
    .wdata_i (pixel_i),
    .re_i    (ram_re),
    .raddr_i (replay_col_q),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o      = run_valid_q;
  assign out_pixel_o      = from_ram_q ? ram_rdata : pix_q;
  assign run_last_o       = (cnt_q == '0);
  assign row_end_o        = end_q && run_last_o;
  assign pad_bytes_o      = row_end_o ? pad_q : '0;
  assign replay_pending_o = pend_q;
  assign error_o          = err_q;

  // a taken transaction always leaves a run behind
  a_accept_gives_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted transaction produced no result");

  // no new transaction while results of the current run remain
  a_no_accept_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_valid_q && (cnt_q != '0) |-> in_stall_o)
    else $error("transaction accepted during a run");

  // an error run is a single result
  a_error_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> run_last_o && !row_end_o)
    else $error("error result not single");

  // replay pointer never moves while no replays are owed
  a_replay_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (replays_q == '0) |=> (replay_col_q == '0) || ($past(replays_q) != '0))
    else $error("replay column moved with no replay owed");

endmodule

`default_nettype wire

// File: src/bpru_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module bpru_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [AddrWidth-1:0] waddr_i,
  input  wire logic [Width-1:0]     wdata_i,
  input  wire logic                 re_i,
  input  wire logic [AddrWidth-1:0] raddr_i,
  output logic      [Width-1:0]     rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: test/tb.sv
// testbench of the pixel replicating upscaler: directed table, then random rows checked live
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bpru_pkg::*;

  localparam int unsigned HoldCycles    = 48;
  localparam int unsigned StallLimit    = 2000;
  localparam int unsigned DrainCycles   = 40;
  localparam int unsigned NumPhases     = 10;
  localparam int unsigned MaxPrints     = 40;
  localparam int unsigned NumDir        = 20;
  localparam int unsigned WideRowPixels = 8;

  typedef struct packed {
    logic [PixelWidth-1:0] pixel;
    logic [PadWidth-1:0]   pad;
    logic                  row_end;
    logic                  run_last;
    logic                  pending;
    logic                  error;
  } upscaled_t;

  typedef enum logic {
    StepCfg,
    StepItem
  } step_kind_e;

  typedef struct packed {
    step_kind_e              kind;
    cfg_idx_e                idx;
    logic [CfgDataWidth-1:0] data;
    action_e                 action;
    logic [PixelWidth-1:0]   pixel;
    logic                    typed;
    upscaled_t               want;
  } step_t;

  localparam upscaled_t NoWant  = '0;
  localparam upscaled_t ErrIdle = '{'0, '0, 1'b0, 1'b1, 1'b0, 1'b1};
  localparam upscaled_t ErrOwed = '{'0, '0, 1'b0, 1'b1, 1'b1, 1'b1};

  localparam step_t DirSteps [NumDir] = '{
    '{StepItem, CfgScale, 11'h000, ActPixel, 24'hFFFFFF, 1'b1,
      '{24'hFFFFFF, 2'd1, 1'b1, 1'b1, 1'b0, 1'b0}},
    '{StepItem, CfgScale, 11'h000, ActPixel, 24'h000000, 1'b1,
      '{24'h000000, 2'd1, 1'b1, 1'b1, 1'b0, 1'b0}},
    '{StepItem, CfgScale, 11'h000, ActAdvance, 24'hA5A5A5, 1'b1, ErrIdle},
    // zero scale and zero width both act as one
    '{StepCfg, CfgScale, 11'h000, ActPixel, 24'h0, 1'b0, NoWant},
    '{StepCfg, CfgRowPixels, 11'h000, ActPixel, 24'h0, 1'b0, NoWant},
    '{StepItem, CfgScale, 11'h000, ActPixel, 24'h5A5A5A, 1'b1,
      '{24'h5A5A5A, 2'd1, 1'b1, 1'b1, 1'b0, 1'b0}},
    // all data bits set: scale clamps to the maximum
    '{StepCfg, CfgScale, 11'h7FF, ActPixel, 24'h0, 1'b0, NoWant},
    '{StepCfg, CfgRowPixels, 11'h005, ActPixel, 24'h0, 1'b0, NoWant},
    '{StepItem, CfgScale, 11'h000, ActPixel, 24'h123456, 1'b0, NoWant},
    '{StepItem, CfgScale, 11'h000, ActPixel, 24'h0F0F0F, 1'b0, NoWant},
    '{StepItem, CfgScale, 11'h000, ActAdvance, 24'h000000, 1'b1, ErrIdle},
    // width shrunk mid-row, the next pixel closes the row
    '{StepCfg, CfgRowPixels, 11'h002, ActPixel, 24'h0, 1'b0, NoWant},
    '{StepItem, CfgScale, 11'h000, ActPixel, 24'hF0F0F0, 1'b0, NoWant},
    '{StepItem, CfgScale, 11'h000, ActPixel, 24'h654321, 1'b1, ErrOwed},
    '{StepItem, CfgScale, 11'h000, ActAdvance, 24'hFFFFFF, 1'b0, NoWant},
    // scale change mid-replay keeps the owed row count
    '{StepCfg, CfgScale, 11'h002, ActPixel, 24'h0, 1'b0, NoWant},
    '{StepCfg, CfgRowPixels, 11'h001, ActPixel, 24'h0, 1'b0, NoWant},
    '{StepItem, CfgScale, 11'h000, ActAdvance, 24'h000000, 1'b0, NoWant},
    '{StepCfg, CfgScale, 11'h003, ActPixel, 24'h0, 1'b0, NoWant},
    '{StepItem, CfgScale, 11'h000, ActAdvance, 24'h000000, 1'b0, NoWant}
  };

  logic                    clk_i            = 1'b0;
  logic                    rst_ni           = 1'b0;
  logic                    cfg_valid_i      = 1'b0;
  logic                    cfg_ready_o;
  logic [CfgIdxWidth-1:0]  cfg_index_i      = '0;
  logic [CfgDataWidth-1:0] cfg_data_i       = '0;
  logic                    in_valid_i       = 1'b0;
  logic                    in_stall_o;
  logic                    action_i         = 1'b0;
  logic [PixelWidth-1:0]   pixel_i          = '0;
  logic                    out_valid_o;
  logic                    out_stall_i      = 1'b0;
  logic [PixelWidth-1:0]   out_pixel_o;
  logic [PadWidth-1:0]     pad_bytes_o;
  logic                    row_end_o;
  logic                    run_last_o;
  logic                    replay_pending_o;
  logic                    error_o;

  // own copy of the upscaler state
  logic [PixelWidth-1:0]  row_buf [MaxRowPixels];
  bit                     row_buf_set [MaxRowPixels];
  int unsigned            wr_col    = 0;
  int unsigned            rd_col    = 0;
  int unsigned            rows_owed = 0;
  logic [ScaleWidth-1:0]  zoom      = ScaleReset;
  logic [RowPixWidth-1:0] row_len   = RowPixReset;

  upscaled_t   upscaled_q [$];
  upscaled_t   burst_q [$];
  int unsigned mismatches   = 0;
  bit          calm         = 1'b0;
  bit          in_quiet     = 1'b0;
  bit          out_quiet    = 1'b0;
  bit          hold_off_req = 1'b0;

  bmp_pixel_replicating_upscaler i_dut (.*);

  always #1 clk_i = ~clk_i;

  function automatic int unsigned eff_len(int unsigned v);
    if (v == 0) return 1;
    if (v > MaxRowPixels) return MaxRowPixels;
    return v;
  endfunction

  // results that one accepted transaction causes, left in burst_q
  task automatic replicate_item(input action_e act, input logic [PixelWidth-1:0] pix_in);
    int unsigned           n;
    int unsigned           w;
    logic [PadWidth-1:0]   pad;
    logic [PixelWidth-1:0] pix;
    logic                  row_done;
    n   = (zoom == 0) ? 1 : ((zoom > MaxScale) ? MaxScale : zoom);
    w   = eff_len(row_len);
    pad = PadWidth'(w * n);
    burst_q.delete();
    if ((act == ActPixel) != (rows_owed == 0)) begin
      burst_q.push_back('{'0, '0, 1'b0, 1'b1, rows_owed != 0, 1'b1});
      return;
    end
    if (act == ActPixel) begin
      pix = pix_in;
      row_buf[wr_col]     = pix;
      row_buf_set[wr_col] = 1'b1;
      row_done = (wr_col + 1 >= w);
      if (row_done) begin
        wr_col    = 0;
        rows_owed = (n - 1) & 4'hF;
        rd_col    = 0;
      end else begin
        wr_col++;
      end
    end else begin
      pix = row_buf[rd_col];
      row_done = (rd_col + 1 >= w);
      if (row_done) begin
        rd_col = 0;
        rows_owed--;
      end else begin
        rd_col++;
      end
    end
    for (int k = 0; k < n; k++) begin
      burst_q.push_back('{pix, (row_done && k == n - 1) ? pad : '0,
                         row_done && k == n - 1, k == n - 1, rows_owed != 0, 1'b0});
    end
  endtask

  task automatic push_item(input action_e act, input logic [PixelWidth-1:0] pix,
                           input logic typed, input upscaled_t want);
    cfg_valid_i <= 1'b0;
    if (!calm && !in_quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    if ($urandom_range(0, 47) == 0) in_quiet = !in_quiet;
    in_valid_i <= 1'b1;
    action_i   <= act;
    pixel_i    <= pix;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    replicate_item(act, pix);
    if (typed) upscaled_q.push_back(want);
    else foreach (burst_q[k]) upscaled_q.push_back(burst_q[k]);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    if (upscaled_q.size() != 0) begin
      cfg_valid_i <= 1'b0;
      do @(posedge clk_i); while (upscaled_q.size() != 0);
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataWidth-1:0] data);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CfgScale) zoom = data[ScaleWidth-1:0];
    else row_len = data;
  endtask

  task automatic flag_mismatch(input string msg);
    if (mismatches < MaxPrints) $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic cmp_field(input string name, input logic [PixelWidth-1:0] got,
                           input logic [PixelWidth-1:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
  endtask

  always @(posedge clk_i) begin : result_check
    upscaled_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (upscaled_q.size() == 0) begin
        flag_mismatch("result transaction with nothing outstanding");
      end else begin
        want = upscaled_q.pop_front();
        cmp_field("out_pixel", out_pixel_o, want.pixel);
        cmp_field("pad_bytes", PixelWidth'(pad_bytes_o), PixelWidth'(want.pad));
        cmp_field("row_end", PixelWidth'(row_end_o), PixelWidth'(want.row_end));
        cmp_field("run_last", PixelWidth'(run_last_o), PixelWidth'(want.run_last));
        cmp_field("replay_pending", PixelWidth'(replay_pending_o),
                  PixelWidth'(want.pending));
        cmp_field("error", PixelWidth'(error_o), PixelWidth'(want.error));
      end
    end
  end

  initial begin : sink_pacing
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        // long hold-off so the block backs up into its input
        hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!calm && !out_quiet && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(1, 5);
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if ($urandom_range(0, 63) == 0) begin
        out_quiet = !out_quiet;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("[bmp_pixel_replicating_upscaler] ERROR");
    $finish;
  end

  initial begin : stimulus
    action_e                 act;
    logic                    wrong;
    int unsigned             s;
    int unsigned             len;
    int unsigned             batch;
    logic [CfgDataWidth-1:0] data;
    bit                      len_ok;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < NumDir; i++) begin
      if (DirSteps[i].kind == StepCfg) begin
        write_reg(DirSteps[i].idx, DirSteps[i].data);
      end else begin
        push_item(DirSteps[i].action, DirSteps[i].pixel, DirSteps[i].typed,
                  DirSteps[i].want);
      end
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      calm = (ph >= NumPhases - 2);
      if (ph == NumPhases / 2) begin
        // unit width reaches a row boundary quickly, then a few pixels at the widest setting
        write_reg(CfgRowPixels, CfgDataWidth'(1));
        while (rows_owed != 0 || wr_col != 0) begin
          push_item(rows_owed != 0 ? ActAdvance : ActPixel, PixelWidth'($urandom), 1'b0,
                    NoWant);
        end
        write_reg(CfgScale, CfgDataWidth'(1));
        write_reg(CfgRowPixels, '1);
        repeat (WideRowPixels) push_item(ActPixel, PixelWidth'($urandom), 1'b0, NoWant);
      end else begin
        if ($urandom_range(0, 2) != 0) begin
          case ($urandom_range(0, 5))
            0:       s = 0;
            1:       s = 1;
            2:       s = MaxScale;
            3:       s = $urandom_range(MaxScale + 1, 31);
            default: s = $urandom_range(2, MaxScale - 1);
          endcase
          data = CfgDataWidth'($urandom);
          data[ScaleWidth-1:0] = ScaleWidth'(s);
          write_reg(CfgScale, data);
        end
        if ($urandom_range(0, 2) != 0) begin
          case ($urandom_range(0, 7))
            0:       len = 0;
            1:       len = 1;
            2:       len = $urandom_range(10, 40);
            default: len = $urandom_range(2, 9);
          endcase
          // mid-replay the new width may only reach entries already filled
          len_ok = 1'b1;
          if (rows_owed != 0) begin
            for (int c = 0; c < eff_len(len); c++) begin
              if (!row_buf_set[c]) len_ok = 1'b0;
            end
          end
          if (len_ok) write_reg(CfgRowPixels, CfgDataWidth'(len));
        end
        if (ph == 1) hold_off_req = 1'b1;
        batch = $urandom_range(4, 10);
        repeat (batch) begin
          wrong = ($urandom_range(0, 9) == 0);
          act   = ((rows_owed == 0) != wrong) ? ActPixel : ActAdvance;
          push_item(act, PixelWidth'($urandom), 1'b0, NoWant);
        end
      end
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[bmp_pixel_replicating_upscaler] OK");
    end else begin
      $display("[bmp_pixel_replicating_upscaler] ERROR");
    end
    $finish;
  end

endmodule
